>>> rtl/bfr_pkg.sv
package bfr_pkg;

	// Fixed font geometry
	localparam int GLYPH_COUNT = 95;
	localparam int FHW         = 7;   // effective font height, up to 127 rows
	localparam int FWW         = 5;   // effective font width, up to 16 pixels

	// Character codes
	localparam logic [7:0] NEWLINE_CODE    = 8'd10;
	localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
	localparam logic [7:0] LAST_PRINTABLE  = 8'd126;

	// Item modes
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_CHAR = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FONT_WIDTH    = 2'd2;
	localparam logic [1:0] REG_FONT_HEIGHT   = 2'd3;

	// One glyph to draw, handed from the cursor unit to the row emitter
	typedef struct packed {
		logic             start;
		logic [6:0]       glyph;   // code minus first printable
		logic [FHW-1:0]   rows;
		logic [15:0]      x;
		logic [15:0]      y;
		logic [15:0]      color;
		logic [15:0]      mask;
	} bfr_job_t;

endpackage

>>> rtl/bfr_ram.sv
module bfr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 3040
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; read data holds without re
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bfr_cursor.sv
module bfr_cursor
	import bfr_pkg::*;
#(
	parameter int DEPTH = 3040,
	parameter int AW    = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            mode,
	input  logic            first_of_string,
	input  logic [15:0]     origin_x,
	input  logic [15:0]     origin_y,
	input  logic [15:0]     ink_color,
	input  logic [7:0]      char_code,
	input  logic [11:0]     load_address,
	input  logic [15:0]     load_word,
	input  logic [15:0]     screen_width,
	input  logic [15:0]     screen_height,
	input  logic [FWW-1:0]  fw,
	input  logic [FHW-1:0]  fh,
	input  logic            busy,
	output logic            ram_we,
	output logic [AW-1:0]   ram_waddr,
	output logic [15:0]     ram_wdata,
	output bfr_job_t        job
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WRAP  = 2'd1;
	localparam logic [1:0] ST_CHECK = 2'd2;

	logic [1:0]  state_q;
	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [15:0] line_start_q;
	logic [15:0] color_q;
	logic        halted_q;
	logic [7:0]  code_q;

	logic        accept;
	logic        wrap;
	logic        bottom;
	logic        printable;
	logic [15:0] next_line_y;

	assign in_ready = (state_q == ST_IDLE) && !busy;
	assign accept   = in_valid && in_ready;

	// Store loads go straight to the RAM; out-of-range addresses are dropped
	assign ram_we    = accept && (mode == MODE_LOAD) && (32'(load_address) < 32'(DEPTH));
	assign ram_waddr = AW'(load_address);
	assign ram_wdata = load_word;

	// Edge tests without wrap, coordinate updates modulo 2^16
	assign next_line_y = cursor_y_q + 16'(fh);
	assign wrap   = (17'(cursor_x_q) + 17'(fw)) > 17'(screen_width);
	assign bottom = (17'(cursor_y_q) + 17'(fh)) > 17'(screen_height);

	always_comb begin
		printable = code_q inside {[FIRST_PRINTABLE:LAST_PRINTABLE]};
	end

	// Glyph job leaves from the bottom check with the pre-advance cursor
	always_comb begin
		job.start = (state_q == ST_CHECK) && !bottom && printable && (fh != '0);
		job.glyph = 7'(code_q - FIRST_PRINTABLE);
		job.rows  = fh;
		job.x     = cursor_x_q;
		job.y     = cursor_y_q;
		job.color = color_q;
		job.mask  = ~(16'hFFFF >> fw);
	end

	// Character sequencer: take item, wrap or newline, bottom check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			line_start_q <= '0;
			color_q      <= '0;
			halted_q     <= 1'b0;
			code_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && (mode == MODE_CHAR)) begin
						code_q <= char_code;
						if (first_of_string) begin
							cursor_x_q   <= origin_x;
							cursor_y_q   <= origin_y;
							line_start_q <= origin_x;
							color_q      <= ink_color;
							halted_q     <= 1'b0;
						end
						if (first_of_string || !halted_q) begin
							state_q <= ST_WRAP;
						end
					end
				end
				ST_WRAP: begin
					if (code_q == NEWLINE_CODE) begin
						cursor_x_q <= line_start_q;
						cursor_y_q <= next_line_y;
						state_q    <= ST_IDLE;
					end else begin
						if (wrap) begin
							cursor_x_q <= line_start_q;
							cursor_y_q <= next_line_y;
						end
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (bottom) begin
						halted_q <= 1'b1;
					end else begin
						cursor_x_q <= cursor_x_q + 16'(fw);
					end
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/bfr_rows.sv
module bfr_rows
	import bfr_pkg::*;
#(
	parameter int AW = 12
) (
	input  logic            clk,
	input  logic            arst_n,
	input  bfr_job_t        job,
	output logic            busy,
	output logic            ram_re,
	output logic [AW-1:0]   ram_raddr,
	input  logic [15:0]     ram_rdata,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [15:0]     pixel_x,
	output logic [15:0]     pixel_y,
	output logic [15:0]     row_bits,
	output logic [15:0]     pen_color,
	output logic            last_row
);

	logic            active_q;
	logic [AW-1:0]   base_q;
	logic [FHW-1:0]  idx_q;
	logic [FHW-1:0]  rows_q;
	logic [15:0]     x_q;
	logic [15:0]     y_q;
	logic [15:0]     color_q;
	logic [15:0]     mask_q;

	logic            valid_s1;
	logic [15:0]     y_s1;
	logic            last_s1;

	logic            out_valid_q;

	logic [13:0]     glyph_base;
	logic            out_free;
	logic            issue;
	logic            move_s1;
	logic            last_issue;

	assign glyph_base = job.glyph * job.rows;
	assign out_free   = !out_valid_q || out_ready;
	assign issue      = active_q && (!valid_s1 || out_free);
	assign move_s1    = valid_s1 && out_free;
	assign last_issue = (idx_q + 7'd1) == rows_q;

	assign busy      = active_q || valid_s1;
	assign ram_re    = issue;
	assign ram_raddr = base_q + AW'(idx_q);
	assign out_valid = out_valid_q;

	// Row counter: one store read per cycle while the pipe can advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (job.start) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (issue) begin
			idx_q <= idx_q + 7'd1;
			if (last_issue) begin
				active_q <= 1'b0;
			end
		end
	end

	// Glyph parameters, held for the whole glyph
	always_ff @(posedge clk) begin
		if (job.start) begin
			base_q  <= glyph_base[AW-1:0];
			rows_q  <= job.rows;
			x_q     <= job.x;
			y_q     <= job.y;
			color_q <= job.color;
			mask_q  <= job.mask;
		end
	end

	// Read stage: row metadata travels alongside the RAM read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			y_s1    <= y_q + 16'(idx_q);
			last_s1 <= last_issue;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			pixel_x   <= x_q;
			pixel_y   <= y_s1;
			row_bits  <= ram_rdata & mask_q;
			pen_color <= color_q;
			last_row  <= last_s1;
		end
	end

endmodule

>>> rtl/bitmap_font_text_renderer.sv
// Store load: written straight to the store; loads may follow back to back. Newline: wrap
// state, then idle. Other characters: wrap and bottom-check states, dropped in idle while
// the string is halted. Printable character: one row per cycle while the output does not
// stall (one store read per row), via the read stage and output register; the next item
// waits until the row emitter is idle. Reset clears the cursor, line start, color, halt
// flag and config registers to their defaults; the glyph store is undefined until loaded.
module bitmap_font_text_renderer
	import bfr_pkg::*;
#(
	parameter int MAX_FONT_HEIGHT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic        first_of_string,
	input  logic [15:0] origin_x,
	input  logic [15:0] origin_y,
	input  logic [15:0] ink_color,
	input  logic [7:0]  char_code,
	input  logic [11:0] load_address,
	input  logic [15:0] load_word,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] pixel_x,
	output logic [15:0] pixel_y,
	output logic [15:0] row_bits,
	output logic [15:0] pen_color,
	output logic        last_row
);

	localparam int STORE_DEPTH = GLYPH_COUNT * MAX_FONT_HEIGHT;
	localparam int AW          = $clog2(STORE_DEPTH);

	logic [15:0]    screen_width_q;
	logic [15:0]    screen_height_q;
	logic [4:0]     font_width_q;
	logic [5:0]     font_height_q;

	logic [FWW-1:0] fw;
	logic [FHW-1:0] fh;

	bfr_job_t       job;
	logic           busy;
	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [15:0]    ram_wdata;
	logic           ram_re;
	logic [AW-1:0]  ram_raddr;
	logic [15:0]    ram_rdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= 16'd240;
			screen_height_q <= 16'd320;
			font_width_q    <= 5'd11;
			font_height_q   <= 6'd18;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata;
				REG_FONT_WIDTH:    font_width_q    <= cfg_wdata[4:0];
				REG_FONT_HEIGHT:   font_height_q   <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// Saturated glyph size
	assign fw = (font_width_q > 5'd16) ? 5'd16 : font_width_q;
	assign fh = (7'(font_height_q) > 7'(MAX_FONT_HEIGHT)) ? 7'(MAX_FONT_HEIGHT)
	                                                     : 7'(font_height_q);

	bfr_cursor #(
		.DEPTH (STORE_DEPTH),
		.AW    (AW)
	) u_cursor (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.first_of_string (first_of_string),
		.origin_x        (origin_x),
		.origin_y        (origin_y),
		.ink_color       (ink_color),
		.char_code       (char_code),
		.load_address    (load_address),
		.load_word       (load_word),
		.screen_width    (screen_width_q),
		.screen_height   (screen_height_q),
		.fw              (fw),
		.fh              (fh),
		.busy            (busy),
		.ram_we          (ram_we),
		.ram_waddr       (ram_waddr),
		.ram_wdata       (ram_wdata),
		.job             (job)
	);

	bfr_ram #(
		.WIDTH (16),
		.DEPTH (STORE_DEPTH)
	) u_glyph_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bfr_rows #(
		.AW (AW)
	) u_rows (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (job),
		.busy      (busy),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.row_bits  (row_bits),
		.pen_color (pen_color),
		.last_row  (last_row)
	);

endmodule

>>> sim/bfr_checker.sv
module bfr_checker
	import bfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        mode,
	input  logic        first_of_string,
	input  logic [15:0] origin_x,
	input  logic [15:0] origin_y,
	input  logic [15:0] ink_color,
	input  logic [7:0]  char_code,
	input  logic [11:0] load_address,
	input  logic [15:0] load_word,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] pixel_x,
	input  logic [15:0] pixel_y,
	input  logic [15:0] row_bits,
	input  logic [15:0] pen_color,
	input  logic        last_row,
	output int          mismatches,
	output int          rows_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ROWS    = 32;
	localparam int STORE_WORDS = GLYPH_COUNT * MAX_ROWS;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] bits;
		logic [15:0] color;
		logic        last;
	} glyph_row_t;

	// Shadow registers and text cursor
	logic [15:0] scr_w;
	logic [15:0] scr_h;
	logic [4:0]  font_w_reg;
	logic [5:0]  font_h_reg;
	logic [15:0] cur_x;
	logic [15:0] cur_y;
	logic [15:0] line_x;
	logic [15:0] str_color;
	logic        halted;
	logic [15:0] glyph_mem [STORE_WORDS];

	glyph_row_t rows_q[$];
	glyph_row_t want;
	glyph_row_t got;

	// Work out the glyph rows caused by the item on the input port
	task automatic predict_glyph_rows();
		int fw;
		int fh;
		int mask;
		int addr;
		glyph_row_t r;
		fw = (font_w_reg > 16) ? 16 : int'(font_w_reg);
		fh = (font_h_reg > MAX_ROWS) ? MAX_ROWS : int'(font_h_reg);
		if (mode == MODE_LOAD) begin
			if (load_address < STORE_WORDS)
				glyph_mem[load_address] = load_word;
			return;
		end
		if (first_of_string) begin
			cur_x     = origin_x;
			cur_y     = origin_y;
			line_x    = origin_x;
			str_color = ink_color;
			halted    = 1'b0;
		end
		if (halted)
			return;
		if (char_code == NEWLINE_CODE) begin
			cur_x = line_x;
			cur_y = 16'(32'(cur_y) + fh);
			return;
		end
		// right edge: wrap before drawing, compared without overflow
		if (32'(cur_x) + fw > 32'(scr_w)) begin
			cur_x = line_x;
			cur_y = 16'(32'(cur_y) + fh);
		end
		if (32'(cur_y) + fh > 32'(scr_h)) begin
			halted = 1'b1;
			return;
		end
		if (char_code >= FIRST_PRINTABLE && char_code <= LAST_PRINTABLE) begin
			mask = (32'hFFFF << (16 - fw)) & 32'hFFFF;
			for (int i = 0; i < fh; i++) begin
				addr    = (int'(char_code) - int'(FIRST_PRINTABLE)) * fh + i;
				r.x     = cur_x;
				r.y     = 16'(32'(cur_y) + i);
				r.bits  = (addr < STORE_WORDS) ? (glyph_mem[addr] & mask[15:0]) : 16'h0;
				r.color = str_color;
				r.last  = (i + 1 == fh);
				rows_q.push_back(r);
			end
		end
		cur_x = 16'(32'(cur_x) + fw);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w      = 16'd240;
			scr_h      = 16'd320;
			font_w_reg = 5'd11;
			font_h_reg = 6'd18;
			cur_x      = '0;
			cur_y      = '0;
			line_x     = '0;
			str_color  = '0;
			halted     = 1'b0;
			rows_q.delete();
			mismatches = 0;
		end else begin
			// compare each row transfer against the oldest pending row
			if (out_valid && out_ready) begin
				got = '{pixel_x, pixel_y, row_bits, pen_color, last_row};
				if (rows_q.size() == 0) begin
					if (mismatches < 10)
						$display("%0t: unexpected row x=%h y=%h bits=%h color=%h last=%b",
							$time, got.x, got.y, got.bits, got.color, got.last);
					mismatches++;
				end else begin
					want = rows_q.pop_front();
					if (want != got) begin
						if (mismatches < 10) begin
							$display("%0t: row mismatch", $time);
							$display("  expected x=%h y=%h bits=%h color=%h last=%b",
								want.x, want.y, want.bits, want.color, want.last);
							$display("  actual   x=%h y=%h bits=%h color=%h last=%b",
								got.x, got.y, got.bits, got.color, got.last);
						end
						mismatches++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_glyph_rows();
			if (cfg_we) begin
				case (cfg_addr)
					REG_SCREEN_WIDTH:  scr_w = cfg_wdata;
					REG_SCREEN_HEIGHT: scr_h = cfg_wdata;
					REG_FONT_WIDTH:    font_w_reg = cfg_wdata[4:0];
					REG_FONT_HEIGHT:   font_h_reg = cfg_wdata[5:0];
					default: ;
				endcase
			end
		end
		rows_pending = rows_q.size();
	end

endmodule

>>> sim/tb_top.sv
module tb_top
	import bfr_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_WORDS = GLYPH_COUNT * 32;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic        mode;
		logic        first;
		logic [15:0] ox;
		logic [15:0] oy;
		logic [15:0] color;
		logic [7:0]  code;
		logic [11:0] addr;
		logic [15:0] word;
	} text_item_t;

	localparam int ITEM_W = $bits(text_item_t);

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [15:0] cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic        mode;
	logic        first_of_string;
	logic [15:0] origin_x;
	logic [15:0] origin_y;
	logic [15:0] ink_color;
	logic [7:0]  char_code;
	logic [11:0] load_address;
	logic [15:0] load_word;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [15:0] row_bits;
	logic [15:0] pen_color;
	logic        last_row;
	int          mismatches;
	int          rows_pending;

	// Stimulus-side view of the setup and the glyph store
	logic written [STORE_WORDS];
	logic [7:0] glyph_pool [2];
	int   rows_cap;
	int   scr_w_cfg;
	int   scr_h_cfg;
	int   chars_sent = 0;
	bit   no_gaps = 1'b0;
	bit   want_hold = 1'b0;
	bit   hold_done = 1'b0;
	int   quiet = 0;

	bitmap_font_text_renderer dut (.*);
	bfr_checker chk (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Watchdog: too long without any transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] random_word();
		return ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
	endfunction

	// Printable codes come from a small pool so the store loads stay few
	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return glyph_pool[$urandom_range(0, 1)];
		if (r < 16)
			return NEWLINE_CODE;
		// codes outside the printable range: 0 to 31 and 127 to 255
		r = $urandom_range(0, 160);
		return 8'((r < 32) ? r : r + 95);
	endfunction

	// Offer one item and hold it until the transfer
	task automatic offer(text_item_t it);
		int gap;
		gap = no_gaps ? 0 : gap_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		mode            <= it.mode;
		first_of_string <= it.first;
		origin_x        <= it.ox;
		origin_y        <= it.oy;
		ink_color       <= it.color;
		char_code       <= it.code;
		load_address    <= it.addr;
		load_word       <= it.word;
		in_valid        <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_load(logic [11:0] addr, logic [15:0] word);
		text_item_t it;
		it = text_item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
		it.mode = MODE_LOAD;
		it.addr = addr;
		it.word = word;
		if (addr < STORE_WORDS)
			written[addr] = 1'b1;
		offer(it);
	endtask

	// A printable glyph is loaded first wherever its rows are still unwritten
	task automatic send_char(logic first, logic [15:0] ox, logic [15:0] oy,
			logic [15:0] ink, logic [7:0] code);
		text_item_t it;
		int a;
		if (code >= FIRST_PRINTABLE && code <= LAST_PRINTABLE) begin
			for (int i = 0; i < rows_cap; i++) begin
				a = (int'(code) - int'(FIRST_PRINTABLE)) * rows_cap + i;
				if (!written[a])
					send_load(12'(a), random_word());
			end
		end
		it = text_item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
		it.mode  = MODE_CHAR;
		it.first = first;
		it.code  = code;
		if (first) begin
			it.ox    = ox;
			it.oy    = oy;
			it.color = ink;
		end
		offer(it);
		chars_sent++;
	endtask

	// Wait until every pending row has left and the block has gone quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rows_pending != 0)
			@(negedge clk);
		repeat (24) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
	endtask

	task automatic setup_panel(int w, int h, int fw, int fh);
		settle();
		write_reg(REG_SCREEN_WIDTH, 16'(w));
		write_reg(REG_SCREEN_HEIGHT, 16'(h));
		write_reg(REG_FONT_WIDTH, 16'(fw));
		write_reg(REG_FONT_HEIGHT, 16'(fh));
		@(negedge clk);
		cfg_we <= 1'b0;
		scr_w_cfg = w;
		scr_h_cfg = h;
		rows_cap  = (fh % 64 > 32) ? 32 : fh % 64;
	endtask

	// Strings with random content, plus stray loads and stray characters
	task automatic run_strings(int quota);
		int stop;
		int pick;
		logic [15:0] ox;
		logic [15:0] oy;
		stop = chars_sent + quota;
		while (chars_sent < stop) begin
			no_gaps = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				send_load(12'($urandom_range(0, 4095)), random_word());
			end else if (pick == 1) begin
				send_char(1'b0, 16'h0, 16'h0, 16'h0, pick_code());
			end else begin
				ox = ($urandom_range(0, 4) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, scr_w_cfg - 1));
				oy = ($urandom_range(0, 4) == 0) ? 16'($urandom)
					: 16'($urandom_range(0, scr_h_cfg - 1));
				send_char(1'b1, ox, oy, 16'($urandom), pick_code());
				repeat ($urandom_range(2, 10))
					send_char(1'b0, 16'h0, 16'h0, 16'h0, pick_code());
			end
		end
		no_gaps = 1'b0;
	endtask

	// Receiver: ready runs and random stalls, one long hold-off on request
	initial begin
		int run;
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready <= 1'b1;
			run = $urandom_range(0, 30);
			repeat (run) @(negedge clk);
			if (want_hold && !hold_done) begin
				stall = HOLD_CYCLES;
				hold_done = 1'b1;
			end else begin
				stall = gap_len();
			end
			if (stall > 0) begin
				@(negedge clk);
				out_ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_addr        = REG_SCREEN_WIDTH;
		cfg_wdata       = '0;
		in_valid        = 1'b0;
		mode            = MODE_LOAD;
		first_of_string = 1'b0;
		origin_x        = '0;
		origin_y        = '0;
		ink_color       = '0;
		char_code       = '0;
		load_address    = '0;
		load_word       = '0;
		foreach (written[a])
			written[a] = 1'b0;
		glyph_pool[0] = "A";
		glyph_pool[1] = LAST_PRINTABLE;
		rows_cap  = 18;
		scr_w_cfg = 240;
		scr_h_cfg = 320;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Defaults after reset: out-of-range loads, all code classes, wrap, halt
		send_load(12'd3040, random_word());
		send_load(12'd4095, 16'hFFFF);
		send_char(1'b1, 16'd0, 16'd0, 16'hFFFF, "A");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, LAST_PRINTABLE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, FIRST_PRINTABLE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, 8'd0);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, 8'd31);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, 8'd127);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, 8'd255);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, NEWLINE_CODE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "A");
		send_char(1'b1, 16'd230, 16'd5, 16'h1234, LAST_PRINTABLE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "A");
		send_char(1'b1, 16'd0, 16'd302, 16'hF800, FIRST_PRINTABLE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, NEWLINE_CODE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "A");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, LAST_PRINTABLE);
		send_char(1'b1, 16'hFFFF, 16'hFFFF, 16'h0000, "A");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, FIRST_PRINTABLE);
		send_char(1'b1, 16'd0, 16'd0, 16'h07E0, NEWLINE_CODE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "A");

		// Largest panel and font
		setup_panel(65535, 65535, 16, 32);
		send_char(1'b1, 16'd65519, 16'd0, 16'hAAAA, "W");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "W");
		send_char(1'b1, 16'd0, 16'd65503, 16'h5555, "W");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, NEWLINE_CODE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "W");

		// Smallest panel and font
		setup_panel(1, 1, 1, 1);
		send_char(1'b1, 16'd0, 16'd0, 16'h00FF, "a");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "b");
		send_char(1'b1, 16'd0, 16'd0, 16'hFF00, NEWLINE_CODE);
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "c");

		// Zero width: blank rows, cursor stays put
		setup_panel(100, 100, 0, 3);
		send_char(1'b1, 16'd10, 16'd10, 16'h0F0F, "K");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "L");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, NEWLINE_CODE);

		// Zero height: no rows, cursor still advances
		setup_panel(100, 100, 5, 0);
		send_char(1'b1, 16'd10, 16'd10, 16'hF0F0, "M");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "N");

		// Oversized width and height saturate
		setup_panel(100, 100, 31, 63);
		send_char(1'b1, 16'd80, 16'd10, 16'h3C3C, "W");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "W");
		send_char(1'b0, 16'h0, 16'h0, 16'h0, "W");

		// Random setups; the first one also stalls the receiver for a long stretch
		for (int p = 0; p < 4; p++) begin
			setup_panel($urandom_range(40, 400), $urandom_range(40, 400),
				$urandom_range(1, 16),
				(p == 3) ? $urandom_range(21, 32) : $urandom_range(1, 12));
			glyph_pool[0] = 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
			glyph_pool[1] = 8'($urandom_range(FIRST_PRINTABLE, LAST_PRINTABLE));
			if (p == 0)
				want_hold = 1'b1;
			run_strings(10);
		end

		settle();
		repeat (30) @(negedge clk);
		if (mismatches == 0 && rows_pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
